### hdl/vmpc_pkg.sv
// Package for the VMPC stream cipher engine: widths, request and register
// codes, and the command/status types between controller and datapath.
// No dependencies.
package vmpc_pkg;

  localparam int BYTE_W          = 8;
  localparam int PERM_DEPTH      = 256;
  localparam int REQ_W           = 3;
  localparam int IDX_W           = 6;
  localparam int LEN_W           = 7;
  localparam int CFG_IDX_W       = 2;
  localparam int DEF_STORE_DEPTH = 64;
  localparam int DEF_ROUND_STEPS = 768;

  localparam logic [REQ_W-1:0] REQ_LOAD_KEY = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_IV  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_RESET    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_KEYSCHED = 3'd3;
  localparam logic [REQ_W-1:0] REQ_ENCRYPT  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IV_LEN  = 2'd1;

  localparam logic [LEN_W-1:0] LEN_RESET = 7'd16;

  // permutation read address select
  localparam logic [1:0] RA_N        = 2'd0;
  localparam logic [1:0] RA_SUM      = 2'd1;
  localparam logic [1:0] RA_DATA     = 2'd2;
  localparam logic [1:0] RA_DATA_INC = 2'd3;

  // permutation write select (address, data)
  localparam logic [1:0] WR_INIT = 2'd0;  // P[n] = n
  localparam logic [1:0] WR_N_RD = 2'd1;  // P[n] = read data
  localparam logic [1:0] WR_N_PS = 2'd2;  // P[n] = saved P[s]
  localparam logic [1:0] WR_S_PN = 2'd3;  // P[s] = saved P[n]

  typedef struct packed {
    logic       take;
    logic [1:0] raddr_sel;
    logic       add_store;
    logic       iv_round;
    logic       pn_load;
    logic       s_load;
    logic       ps_load;
    logic       res_load;
    logic       we;
    logic [1:0] wsel;
    logic       n_inc;
    logic       n_clr;
    logic       ns_clr;
    logic       idx_clr;
    logic       idx_adv;
    logic       push;
  } cmd_t;

  typedef struct packed {
    logic n_last;
    logic out_free;
  } sts_t;

endpackage

### hdl/vmpc_req_if.sv
// Request channel: valid/ready handshake with request type, index and byte.
// Depends on vmpc_pkg.
interface vmpc_req_if;
  import vmpc_pkg::*;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [IDX_W-1:0]  byte_index;
  logic [BYTE_W-1:0] byte_value;
  modport source (output valid, req_type, byte_index, byte_value, input ready);
  modport sink   (input valid, req_type, byte_index, byte_value, output ready);
endinterface

### hdl/vmpc_res_if.sv
// Result channel: valid/ready handshake with one output byte.
// Depends on vmpc_pkg.
interface vmpc_res_if;
  import vmpc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_out;
  modport source (output valid, data_out, input ready);
  modport sink   (input valid, data_out, output ready);
endinterface

### hdl/vmpc_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// Depends on vmpc_pkg.
interface vmpc_cfg_if;
  import vmpc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [LEN_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/vmpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vmpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/vmpc_ctrl.sv
// Sequencer for the VMPC engine: dispatches requests, steps the mixing
// rounds and the encrypt sequence. Depends on vmpc_pkg.
module vmpc_ctrl #(
  parameter int ROUND_STEPS = vmpc_pkg::DEF_ROUND_STEPS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  input  logic [vmpc_pkg::REQ_W-1:0]   req_type,
  output logic                         req_ready,
  input  vmpc_pkg::sts_t               sts,
  output vmpc_pkg::cmd_t               cmd
);
  import vmpc_pkg::*;

  localparam int SW = $clog2(ROUND_STEPS);
  localparam logic [SW-1:0] STEP_LAST = SW'(ROUND_STEPS - 1);

  localparam logic [1:0] ROUND_KEY0 = 2'd0;
  localparam logic [1:0] ROUND_IV   = 2'd1;
  localparam logic [1:0] ROUND_KEY1 = 2'd2;

  localparam logic [3:0] ST_INIT  = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_KS_N  = 4'd2;
  localparam logic [3:0] ST_KS_A  = 4'd3;
  localparam logic [3:0] ST_KS_S  = 4'd4;
  localparam logic [3:0] ST_KS_WN = 4'd5;
  localparam logic [3:0] ST_KS_WS = 4'd6;
  localparam logic [3:0] ST_EN_N  = 4'd7;
  localparam logic [3:0] ST_EN_A  = 4'd8;
  localparam logic [3:0] ST_EN_S  = 4'd9;
  localparam logic [3:0] ST_EN_T  = 4'd10;
  localparam logic [3:0] ST_EN_K  = 4'd11;
  localparam logic [3:0] ST_EN_X  = 4'd12;
  localparam logic [3:0] ST_EN_WS = 4'd13;
  localparam logic [3:0] ST_FIN   = 4'd14;

  logic [3:0]    state, state_next;
  logic [SW-1:0] step, step_next;
  logic [1:0]    round, round_next;
  logic          init_reply, init_reply_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      step       <= '0;
      round      <= ROUND_KEY0;
      init_reply <= 1'b0;
    end else begin
      state      <= state_next;
      step       <= step_next;
      round      <= round_next;
      init_reply <= init_reply_next;
    end
  end

  always_comb begin
    state_next      = state;
    step_next       = step;
    round_next      = round;
    init_reply_next = init_reply;
    cmd             = '0;
    cmd.iv_round    = (round == ROUND_IV);
    req_ready       = (state == ST_IDLE);
    case (state)
      ST_INIT: begin
        cmd.we   = 1'b1;
        cmd.wsel = WR_INIT;
        cmd.n_inc = 1'b1;
        if (sts.n_last) begin
          state_next      = init_reply ? ST_FIN : ST_IDLE;
          init_reply_next = 1'b0;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          cmd.take = 1'b1;
          case (req_type)
            REQ_RESET: begin
              cmd.ns_clr      = 1'b1;
              init_reply_next = 1'b1;
              state_next      = ST_INIT;
            end
            REQ_KEYSCHED: begin
              cmd.n_clr   = 1'b1;
              cmd.idx_clr = 1'b1;
              step_next   = '0;
              round_next  = ROUND_KEY0;
              state_next  = ST_KS_N;
            end
            REQ_ENCRYPT: state_next = ST_EN_N;
            default:     state_next = ST_FIN;
          endcase
        end
      end
      ST_KS_N: begin
        cmd.raddr_sel = RA_N;
        state_next    = ST_KS_A;
      end
      ST_KS_A: begin
        cmd.pn_load   = 1'b1;
        cmd.add_store = 1'b1;
        cmd.raddr_sel = RA_SUM;
        state_next    = ST_KS_S;
      end
      ST_KS_S: begin
        cmd.s_load    = 1'b1;
        cmd.raddr_sel = RA_DATA;
        state_next    = ST_KS_WN;
      end
      ST_KS_WN: begin
        cmd.we     = 1'b1;
        cmd.wsel   = WR_N_RD;
        state_next = ST_KS_WS;
      end
      ST_KS_WS: begin
        cmd.we   = 1'b1;
        cmd.wsel = WR_S_PN;
        if (step == STEP_LAST) begin
          step_next = '0;
          if (round == ROUND_KEY1) begin
            cmd.n_inc  = 1'b1;
            state_next = ST_FIN;
          end else begin
            cmd.n_clr   = 1'b1;
            cmd.idx_clr = 1'b1;
            round_next  = round + 2'd1;
            state_next  = ST_KS_N;
          end
        end else begin
          cmd.n_inc   = 1'b1;
          cmd.idx_adv = 1'b1;
          step_next   = step + SW'(1);
          state_next  = ST_KS_N;
        end
      end
      ST_EN_N: begin
        cmd.raddr_sel = RA_N;
        state_next    = ST_EN_A;
      end
      ST_EN_A: begin
        cmd.pn_load   = 1'b1;
        cmd.raddr_sel = RA_SUM;
        state_next    = ST_EN_S;
      end
      ST_EN_S: begin
        cmd.s_load    = 1'b1;
        cmd.raddr_sel = RA_DATA;
        state_next    = ST_EN_T;
      end
      ST_EN_T: begin
        cmd.ps_load   = 1'b1;
        cmd.raddr_sel = RA_DATA;
        state_next    = ST_EN_K;
      end
      ST_EN_K: begin
        cmd.raddr_sel = RA_DATA_INC;
        state_next    = ST_EN_X;
      end
      ST_EN_X: begin
        cmd.res_load = 1'b1;
        cmd.we       = 1'b1;
        cmd.wsel     = WR_N_PS;
        state_next   = ST_EN_WS;
      end
      ST_EN_WS: begin
        cmd.we     = 1'b1;
        cmd.wsel   = WR_S_PN;
        cmd.n_inc  = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_encrypt_len: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && (req_type == REQ_ENCRYPT)) |-> ##8 (state == ST_FIN))
    else $error("encrypt request did not reach finish in eight cycles");

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    (round == ROUND_KEY0) || (round == ROUND_IV) || (round == ROUND_KEY1))
    else $error("round counter out of range");

  a_step_hold: assert property (@(posedge clk) disable iff (rst)
    ((state != ST_KS_WS) && !cmd.take) |=> $stable(step))
    else $error("step counter moved outside a swap step");

endmodule

### hdl/vmpc_dp.sv
// Datapath for the VMPC engine: permutation RAM, key and IV stores, s/n
// registers, length registers and the result register. Depends on vmpc_pkg
// and vmpc_ram.
module vmpc_dp #(
  parameter int STORE_DEPTH = vmpc_pkg::DEF_STORE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  vmpc_pkg::cmd_t                  cmd,
  output vmpc_pkg::sts_t                  sts,
  input  logic [vmpc_pkg::REQ_W-1:0]      req_type,
  input  logic [vmpc_pkg::IDX_W-1:0]      byte_index,
  input  logic [vmpc_pkg::BYTE_W-1:0]     byte_value,
  input  logic                            cfg_valid,
  input  logic [vmpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vmpc_pkg::LEN_W-1:0]      cfg_data,
  output logic                            out_valid,
  output logic [vmpc_pkg::BYTE_W-1:0]     out_data,
  input  logic                            out_ready
);
  import vmpc_pkg::*;

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [7:0] DEPTH8 = 8'(STORE_DEPTH);
  localparam logic [BYTE_W-1:0] N_LAST = BYTE_W'(PERM_DEPTH - 1);

  logic [BYTE_W-1:0] s, n, pn, ps, val, res;
  logic [REQ_W-1:0]  req_q;
  logic [AW-1:0]     idx;
  logic [LEN_W-1:0]  key_len, iv_len;

  logic [BYTE_W-1:0] perm_rdata, perm_raddr, perm_waddr, perm_wdata;
  logic [BYTE_W-1:0] key_rdata, iv_rdata, store_byte, sum;
  logic              in_range, key_we, iv_we;
  logic [AW-1:0]     store_waddr;
  logic [7:0]        len8, eff_len, idx_inc;

  assign in_range    = (9'(byte_index) < 9'(STORE_DEPTH));
  assign key_we      = cmd.take && (req_type == REQ_LOAD_KEY) && in_range;
  assign iv_we       = cmd.take && (req_type == REQ_LOAD_IV) && in_range;
  assign store_waddr = AW'(byte_index);

  vmpc_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_DEPTH)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(store_waddr), .wdata(byte_value),
    .raddr(idx), .rdata(key_rdata)
  );

  vmpc_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_DEPTH)) u_iv_ram (
    .clk(clk), .we(iv_we), .waddr(store_waddr), .wdata(byte_value),
    .raddr(idx), .rdata(iv_rdata)
  );

  vmpc_ram #(.WIDTH(BYTE_W), .DEPTH(PERM_DEPTH)) u_perm_ram (
    .clk(clk), .we(cmd.we), .waddr(perm_waddr), .wdata(perm_wdata),
    .raddr(perm_raddr), .rdata(perm_rdata)
  );

  assign store_byte = cmd.iv_round ? iv_rdata : key_rdata;
  assign sum = s + perm_rdata + (cmd.add_store ? store_byte : '0);

  always_comb begin
    case (cmd.raddr_sel)
      RA_N:        perm_raddr = n;
      RA_SUM:      perm_raddr = sum;
      RA_DATA:     perm_raddr = perm_rdata;
      RA_DATA_INC: perm_raddr = perm_rdata + 8'd1;
      default:     perm_raddr = n;
    endcase
    case (cmd.wsel)
      WR_INIT: begin
        perm_waddr = n;
        perm_wdata = n;
      end
      WR_N_RD: begin
        perm_waddr = n;
        perm_wdata = perm_rdata;
      end
      WR_N_PS: begin
        perm_waddr = n;
        perm_wdata = ps;
      end
      WR_S_PN: begin
        perm_waddr = s;
        perm_wdata = pn;
      end
      default: begin
        perm_waddr = n;
        perm_wdata = n;
      end
    endcase
  end

  // zero acts as one, above depth clamps to depth
  assign len8    = {1'b0, (cmd.iv_round ? iv_len : key_len)};
  assign eff_len = (len8 == 8'd0) ? 8'd1 : ((len8 > DEPTH8) ? DEPTH8 : len8);
  assign idx_inc = 8'(idx) + 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      n         <= '0;
      s         <= '0;
      key_len   <= LEN_RESET;
      iv_len    <= LEN_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cmd.ns_clr || cmd.n_clr) begin
        n <= '0;
      end else if (cmd.n_inc) begin
        n <= n + 8'd1;
      end
      if (cmd.ns_clr) begin
        s <= '0;
      end else if (cmd.s_load) begin
        s <= perm_rdata;
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_KEY_LEN: key_len <= cfg_data;
          CFG_IV_LEN:  iv_len  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      val   <= byte_value;
      req_q <= req_type;
    end
    if (cmd.pn_load) begin
      pn <= perm_rdata;
    end
    if (cmd.ps_load) begin
      ps <= perm_rdata;
    end
    if (cmd.take) begin
      res <= '0;
    end else if (cmd.res_load) begin
      res <= val ^ perm_rdata;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_adv) begin
      idx <= (idx_inc >= eff_len) ? '0 : AW'(idx_inc);
    end
    if (cmd.push) begin
      out_data <= res;
    end
  end

  assign sts.n_last   = (n == N_LAST);
  assign sts.out_free = !out_valid || out_ready;

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.push && (req_q != REQ_ENCRYPT)) |-> (res == '0))
    else $error("non-encrypt request produced a nonzero result");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.add_store |-> (8'(idx) < eff_len))
    else $error("store index beyond effective length");

endmodule

### hdl/vmpc_stream_cipher.sv
// VMPC stream cipher engine, one request at a time through a 256-byte
// permutation RAM. Result goes valid after a load or unused-code request,
// an encrypt, a key schedule (key, IV and key mixing rounds) or a reset
// request (identity refill); the next request is taken in the cycle the
// previous result goes valid. Reset (rst, synchronous) runs an identity fill,
// no request taken; config writes always ready, ignored while rst is high.
module vmpc_stream_cipher #(
  parameter int STORE_DEPTH = vmpc_pkg::DEF_STORE_DEPTH,
  parameter int ROUND_STEPS = vmpc_pkg::DEF_ROUND_STEPS
) (
  input logic        clk,
  input logic        rst,
  vmpc_req_if.sink   req,
  vmpc_res_if.source res,
  vmpc_cfg_if.sink   cfg
);
  import vmpc_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic req_ready;

  assign req.ready = req_ready;
  assign cfg.ready = 1'b1;

  vmpc_ctrl #(.ROUND_STEPS(ROUND_STEPS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  vmpc_dp #(.STORE_DEPTH(STORE_DEPTH)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .req_type   (req.req_type),
    .byte_index (req.byte_index),
    .byte_value (req.byte_value),
    .cfg_valid  (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .out_valid  (res.valid),
    .out_data   (res.data_out),
    .out_ready  (res.ready)
  );

endmodule
